>>> sv/dns_question_parser_macros.svh
// Assertion macros used by the checker file of the DNS question parser.
`ifndef DNS_QUESTION_PARSER_MACROS_SVH
`define DNS_QUESTION_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DQP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DQP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/dqp_pkg.sv
`timescale 1ns / 1ps

package dqp_pkg;

    // Record kinds carried on the output tuser.
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_CHAR   = 2'd1;
    localparam logic [1:0] KIND_QEND   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_SHORT = 2'd1;
    localparam logic [1:0] ERR_TRUNC = 2'd2;

    localparam logic [7:0] DOT_CHAR         = 8'h2E;
    localparam logic [7:0] LIMIT_RESET      = 8'd63;
    localparam logic [3:0] HEADER_LAST_IDX  = 4'd11;

    // Output item, last field in the lowest bits, zero fill on top.
    typedef struct packed {
        logic [2:0]  fill;
        logic [1:0]  error_code;
        logic        long_label;
        logic [15:0] query_class;
        logic [15:0] query_type;
        logic [7:0]  name_char;
        logic [17:0] other_record_count;
        logic [15:0] question_count;
        logic [3:0]  rcode;
        logic [3:0]  opcode;
        logic [15:0] flags_word;
        logic [15:0] message_id;
    } result_t;

endpackage

>>> sv/dns_question_parser.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata = packet_byte, s_tlast = last_byte
// m_*       out        m_tvalid/m_tready  m_tdata = result fields, m_tuser = record_kind
// APB       in         psel/penable       label_warn_limit at byte address 0
//
// Each accepted byte is parsed in the cycle it is accepted and its result, if any,
// lands in the output register at the same edge, so one byte per cycle is sustained
// as long as the output is not stalled.
// The input is stalled only while the output register holds a result not yet taken.
// rst_n clears the parse state and the output valid flag, and sets the limit to 63.
// A byte flagged with s_tlast returns the parser to its reset state; the limit is kept.

module dns_question_parser (
    input  logic         clk,
    input  logic         rst_n,
    // Input byte stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] packet_byte
    input  logic         s_tlast,   // last_byte
    // Output record stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] message_id, [31:16] flags_word, [35:32] opcode, [39:36] rcode,
    // [55:40] question_count, [73:56] other_record_count, [81:74] name_char,
    // [97:82] query_type, [113:98] query_class, [114] long_label,
    // [116:115] error_code, [119:117] zero
    output logic [119:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] record_kind
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN,
        PH_DATA,
        PH_TAIL,
        PH_SKIP
    } phase_t;

    // Parser state.
    phase_t          phase_reg, phase_next;
    logic [3:0]      hdr_idx_reg, hdr_idx_next;
    logic [63:0]     hdr_shift_reg, hdr_shift_next;
    logic [15:0]     q_left_reg, q_left_next;
    logic [7:0]      lbl_left_reg, lbl_left_next;
    logic [23:0]     tail_reg, tail_next;
    logic [1:0]      tail_idx_reg, tail_idx_next;
    logic            long_seen_reg, long_seen_next;

    // Output register.
    logic            m_valid_reg, m_valid_next;
    dqp_pkg::result_t m_data_reg, m_data_next;
    logic [1:0]      m_kind_reg, m_kind_next;

    // Configuration register.
    logic [7:0]      limit_reg;

    logic            accept;
    logic            cfg_write;
    logic            cfg_hit;
    logic            emit;
    dqp_pkg::result_t res;
    logic [1:0]      kind;
    logic [15:0]     q_dec;
    logic [15:0]     hdr_flags;

    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[2] == 1'b0);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
    assign prdata    = cfg_hit ? {24'd0, limit_reg} : 32'd0;

    // The output register can take a new result when empty or being drained.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;

    assign q_dec     = q_left_reg - 16'd1;
    assign hdr_flags = hdr_shift_reg[47:32];

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        hdr_shift_next = hdr_shift_reg;
        q_left_next    = q_left_reg;
        lbl_left_next  = lbl_left_reg;
        tail_next      = tail_reg;
        tail_idx_next  = tail_idx_reg;
        long_seen_next = long_seen_reg;
        emit           = 1'b0;
        res            = '0;
        kind           = dqp_pkg::KIND_HEADER;

        if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    // Bytes 0..7 shift in; the NSCOUNT and ARCOUNT words are summed.
                    if (hdr_idx_reg < 4'd8)
                    begin
                        hdr_shift_next = {hdr_shift_reg[55:0], s_tdata};
                    end
                    else if (hdr_idx_reg == 4'd8 || hdr_idx_reg == 4'd10)
                    begin
                        tail_next = tail_reg + {8'd0, s_tdata, 8'd0};
                    end
                    else
                    begin
                        tail_next = tail_reg + {16'd0, s_tdata};
                    end

                    if (s_tlast)
                    begin
                        emit           = 1'b1;
                        kind           = dqp_pkg::KIND_ERROR;
                        res.error_code = dqp_pkg::ERR_SHORT;
                    end
                    else if (hdr_idx_reg >= dqp_pkg::HEADER_LAST_IDX)
                    begin
                        emit                   = 1'b1;
                        kind                   = dqp_pkg::KIND_HEADER;
                        res.message_id         = hdr_shift_reg[63:48];
                        res.flags_word         = hdr_flags;
                        res.opcode             = hdr_flags[14:11];
                        res.rcode              = hdr_flags[3:0];
                        res.question_count     = hdr_shift_reg[31:16];
                        res.other_record_count = {2'd0, hdr_shift_reg[15:0]}
                                                 + tail_next[17:0];
                        q_left_next    = hdr_shift_reg[31:16];
                        tail_next      = '0;
                        long_seen_next = 1'b0;
                        phase_next     = (hdr_shift_reg[31:16] != 16'd0) ? PH_LEN : PH_SKIP;
                    end
                    else
                    begin
                        hdr_idx_next = hdr_idx_reg + 4'd1;
                    end
                end

                PH_LEN:
                begin
                    if (s_tdata == 8'd0)
                    begin
                        // Empty name: go straight to qtype and qclass.
                        phase_next    = PH_TAIL;
                        tail_idx_next = '0;
                        tail_next     = '0;
                    end
                    else
                    begin
                        if (s_tdata > limit_reg)
                        begin
                            long_seen_next = 1'b1;
                        end
                        lbl_left_next = s_tdata;
                        phase_next    = PH_DATA;
                    end
                end

                PH_DATA:
                begin
                    if (lbl_left_reg != 8'd0)
                    begin
                        lbl_left_next = lbl_left_reg - 8'd1;
                        emit          = 1'b1;
                        kind          = dqp_pkg::KIND_CHAR;
                        res.name_char = s_tdata;
                    end
                    else if (s_tdata == 8'd0)
                    begin
                        phase_next    = PH_TAIL;
                        tail_idx_next = '0;
                        tail_next     = '0;
                    end
                    else
                    begin
                        // A new label starts; a dot separates it from the last one.
                        if (s_tdata > limit_reg)
                        begin
                            long_seen_next = 1'b1;
                        end
                        lbl_left_next = s_tdata;
                        emit          = 1'b1;
                        kind          = dqp_pkg::KIND_CHAR;
                        res.name_char = dqp_pkg::DOT_CHAR;
                    end
                end

                PH_TAIL:
                begin
                    if (tail_idx_reg != 2'd3)
                    begin
                        tail_next     = {tail_reg[15:0], s_tdata};
                        tail_idx_next = tail_idx_reg + 2'd1;
                    end
                    else
                    begin
                        emit            = 1'b1;
                        kind            = dqp_pkg::KIND_QEND;
                        res.query_type  = tail_reg[23:8];
                        res.query_class = {tail_reg[7:0], s_tdata};
                        res.long_label  = long_seen_reg;
                        q_left_next     = q_dec;
                        tail_next       = '0;
                        tail_idx_next   = '0;
                        long_seen_next  = 1'b0;
                        phase_next      = (q_dec != 16'd0) ? PH_LEN : PH_SKIP;
                    end
                end

                PH_SKIP:
                begin
                    // Bytes after the last question are dropped.
                end

                default:
                begin
                end
            endcase

            // A message that ends inside a question is truncated. This also covers
            // a completed question when more questions are still announced.
            if (s_tlast && (phase_reg == PH_LEN || phase_reg == PH_DATA
                || (phase_reg == PH_TAIL && (tail_idx_reg != 2'd3 || q_dec != 16'd0))))
            begin
                emit           = 1'b1;
                kind           = dqp_pkg::KIND_ERROR;
                res            = '0;
                res.error_code = dqp_pkg::ERR_TRUNC;
            end

            if (s_tlast)
            begin
                phase_next     = PH_HEADER;
                hdr_idx_next   = '0;
                hdr_shift_next = '0;
                q_left_next    = '0;
                lbl_left_next  = '0;
                tail_next      = '0;
                tail_idx_next  = '0;
                long_seen_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_kind_next  = m_kind_reg;
        if (accept)
        begin
            m_valid_next = emit;
            if (emit)
            begin
                m_data_next = res;
                m_kind_next = kind;
            end
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_idx_reg   <= '0;
            hdr_shift_reg <= '0;
            q_left_reg    <= '0;
            lbl_left_reg  <= '0;
            tail_reg      <= '0;
            tail_idx_reg  <= '0;
            long_seen_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            hdr_shift_reg <= hdr_shift_next;
            q_left_reg    <= q_left_next;
            lbl_left_reg  <= lbl_left_next;
            tail_reg      <= tail_next;
            tail_idx_reg  <= tail_idx_next;
            long_seen_reg <= long_seen_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Output payload carries no reset; it is qualified by m_valid_reg.
    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_kind_reg <= m_kind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= dqp_pkg::LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            limit_reg <= pwdata[7:0];
        end
    end

endmodule

>>> sv/dqp_checker.sv
`timescale 1ns / 1ps

`include "dns_question_parser_macros.svh"

module dqp_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata,
    input logic [1:0]   m_tuser
);

    dqp_pkg::result_t rec;
    logic             is_err;
    logic             is_hdr;

    assign rec    = m_tdata;
    assign is_err = m_tvalid && (m_tuser == dqp_pkg::KIND_ERROR);
    assign is_hdr = m_tvalid && (m_tuser == dqp_pkg::KIND_HEADER);

    // A stalled record must hold its payload.
    `DQP_ASSERT_NEXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output record changed under stall")

    // With nothing pending at the output, the parser must be able to take a byte.
    `DQP_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready,
        "input stalled while output register is empty")

    // Error records carry a real error code, other records none.
    `DQP_ASSERT_IMPL(a_err_code, clk, rst_n, is_err,
        rec.error_code == dqp_pkg::ERR_SHORT || rec.error_code == dqp_pkg::ERR_TRUNC,
        "error record without a valid error code")
    `DQP_ASSERT_IMPL(a_no_err_code, clk, rst_n, m_tvalid && !is_err,
        rec.error_code == dqp_pkg::ERR_NONE, "non-error record carries an error code")

    // Header opcode and rcode are slices of the flags word.
    `DQP_ASSERT_IMPL(a_hdr_fields, clk, rst_n, is_hdr,
        rec.opcode == rec.flags_word[14:11] && rec.rcode == rec.flags_word[3:0],
        "header opcode or rcode disagrees with flags word")

endmodule

bind dns_question_parser dqp_checker u_dqp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
